// ===== hw/rtl/compacting_indexed_list_macros.svh =====
// Assertion helpers for the RTL.
// Both expect aclk and aresetn in the enclosing scope.
`ifndef COMPACTING_INDEXED_LIST_MACROS_SVH
`define COMPACTING_INDEXED_LIST_MACROS_SVH

// cons must hold in the same cycle as ante
`define CIL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define CIL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cil_pkg.sv =====
package cil_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // request fields
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 32;
    localparam int IN_TDATA_W = 48;

    // result fields
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W  = OUT_TDATA_W - DATA_W - STATUS_W - COUNT_W;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_APPEND = 2'd0;
    localparam cmd_t CMD_READ   = 2'd1;
    localparam cmd_t CMD_WRITE  = 2'd2;
    localparam cmd_t CMD_REMOVE = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_INDEX = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

endpackage

// ===== hw/rtl/cil_ram.sv =====
module cil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/compacting_indexed_list.sv =====
// Compacting indexed list: an ordered list of up to DEPTH words in one
// single-port-write, single-port-read RAM, plus an occupied count.
// Requests arrive on s_tvalid/s_tready/s_tdata; each gives exactly one
// result on m_tvalid/m_tready/m_tdata (data, status, count after request).
// Commands: append at end, read at index, write at index, remove at index.
// A remove returns the removed word and moves every later word down one.
// Index at or past the count -> bad index status, nothing changes.
// Append to a full list -> full status, nothing changes.
// Append, read, write and any rejected request go straight from accept
// to the final step. A remove at a valid index first takes the removed
// word from the RAM, then the RAM moves one word per cycle (read entry
// i+1, write entry i in the cycle after).
// One request is in work at a time; s_tready is high whenever the
// sequencer is idle, also while an earlier result waits in the output
// register. If the receiver stalls, a finished result holds in the final
// step until the output register frees, and no new request is taken.
// Reset (aresetn low, synchronous) empties the list; RAM contents stay
// undefined and are never read before being written.
`include "compacting_indexed_list_macros.svh"

module compacting_indexed_list #(
    parameter int DEPTH     = cil_pkg::DEPTH_DEF,
    parameter int WORD_BITS = cil_pkg::WORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[1:0], index[8:2], value[40:9], zero fill above
    input  logic [cil_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // data[31:0], status[33:32], count[40:34], zero fill above
    output logic [cil_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import cil_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int XW     = (WORD_BITS > DATA_W) ? WORD_BITS : DATA_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request
    localparam logic [1:0] S_REM   = 2'd1;  // removed word arrives from RAM
    localparam logic [1:0] S_SHIFT = 2'd2;  // moving later words down
    localparam logic [1:0] S_FIN   = 2'd3;  // hand result to output reg

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    cmd_t              cmd_reg, cmd_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;       // entry whose word is in rdata
    logic [WORD_BITS-1:0] removed_reg, removed_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    status_t           m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    // request fields
    cmd_t               in_cmd;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic               s_accept;

    logic [CMP_W-1:0]   idx_ext, cnt_ext;
    logic [ADDR_W-1:0]  idx_addr;
    logic               idx_ok;
    logic               full;
    logic [XW-1:0]      value_ext;
    logic [WORD_BITS-1:0] in_word;
    logic [CNT_W-1:0]   ptr_inc;
    logic [XW-1:0]      rd_ext, removed_ext;

    // RAM port
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_index = s_tdata[CMD_W +: INDEX_W];
    assign in_value = s_tdata[CMD_W + INDEX_W +: VALUE_W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // index is valid only below the count (count never exceeds DEPTH)
    assign idx_ext  = CMP_W'(in_index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_ok   = idx_ext < cnt_ext;
    assign idx_addr = idx_ext[ADDR_W-1:0];
    assign full     = (count_reg == CNT_W'(DEPTH));

    // stored words keep the low WORD_BITS bits of the value
    assign value_ext = XW'(in_value);
    assign in_word   = value_ext[WORD_BITS-1:0];

    assign ptr_inc     = CNT_W'(ptr_reg) + CNT_W'(1);
    assign rd_ext      = XW'(ram_rdata);
    assign removed_ext = XW'(removed_reg);

    cil_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        ptr_next      = ptr_reg;
        removed_next  = removed_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = in_word;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = in_cmd;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (in_cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_READ: begin
                            if (!idx_ok) begin
                                status_next = ST_BAD_INDEX;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_addr;
                            end
                        end
                        CMD_WRITE: begin
                            if (!idx_ok) begin
                                status_next = ST_BAD_INDEX;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_addr;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!idx_ok) begin
                                status_next = ST_BAD_INDEX;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = idx_addr;
                                ptr_next   = idx_addr;
                                state_next = S_REM;
                            end
                        end
                    endcase
                end
            end
            S_REM: begin
                removed_next = ram_rdata;
                if (ptr_inc < count_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = ptr_inc[ADDR_W-1:0];
                    ptr_next   = ptr_inc[ADDR_W-1:0];
                    state_next = S_SHIFT;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
            end
            S_SHIFT: begin
                // word of entry ptr moves to ptr-1; next read runs alongside
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (ptr_inc < count_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[ADDR_W-1:0];
                    ptr_next  = ptr_inc[ADDR_W-1:0];
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = cnt_ext[COUNT_W-1:0];
                    if (status_reg == ST_OK && cmd_reg == CMD_READ) begin
                        m_data_next = rd_ext[DATA_W-1:0];
                    end else if (status_reg == ST_OK && cmd_reg == CMD_REMOVE) begin
                        m_data_next = removed_ext[DATA_W-1:0];
                    end else begin
                        m_data_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        ptr_reg      <= ptr_next;
        removed_reg  <= removed_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_count_reg, m_status_reg, m_data_reg};

    `CIL_ASSERT_NEXT(a_append_grows, s_accept && in_cmd == CMD_APPEND && !full, count_reg == $past(count_reg) + CNT_W'(1), "append did not grow the count")
    `CIL_ASSERT_NEXT(a_bad_index_holds, s_accept && in_cmd != CMD_APPEND && !idx_ok, $stable(count_reg), "bad index changed the count")
    `CIL_ASSERT_SAME(a_shift_in_range, state_reg == S_SHIFT, CNT_W'(ptr_reg) < count_reg && ptr_reg != '0, "shift pointer out of range")
    `CIL_ASSERT_SAME(a_ram_ports_split, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write hit the same entry")
    `CIL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count exceeds capacity")

endmodule

// ===== bench/compacting_indexed_list_tb.sv =====
`timescale 1ns / 100ps

module compacting_indexed_list_tb;
    import cil_pkg::*;

    localparam int LIST_DEPTH      = DEPTH_DEF;
    localparam int RANDOM_REQUESTS = 1760;
    localparam int HOLD_CYCLES     = 250;
    localparam int SETTLE_CYCLES   = 100;
    localparam int MAX_REPORTS     = 100;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [7:0]         reps;
        logic               typed;
        list_result_t       want;
    } plan_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the list
    logic [DATA_W-1:0] list_words [0:LIST_DEPTH-1];
    int                list_len = 0;
    int                peak_len = 0;

    list_result_t      pending_results [$];
    plan_row_t         plan [$];

    int  mismatch_count = 0;
    int  cmd_seen [0:3] = '{0, 0, 0, 0};
    int  status_seen [0:3] = '{0, 0, 0, 0};
    int  hold_seq = 0;
    bit  source_gaps_on = 1'b1;
    bit  sink_gaps_on = 1'b1;

    compacting_indexed_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns mismatch %s: got %h, expected %h", $time, what, got, want);
    endtask

    // mostly short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic void apply_to_list(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] val,
                                          output list_result_t res);
        int k;
        res.data   = '0;
        res.status = ST_OK;
        if (cmd == CMD_APPEND) begin
            if (list_len >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                list_words[list_len] = val;
                list_len++;
            end
        end else if (idx >= list_len) begin
            res.status = ST_BAD_INDEX;
        end else if (cmd == CMD_READ) begin
            res.data = list_words[idx];
        end else if (cmd == CMD_WRITE) begin
            list_words[idx] = val;
        end else begin
            // remove: close the gap
            res.data = list_words[idx];
            for (k = int'(idx); k + 1 < list_len; k++)
                list_words[k] = list_words[k + 1];
            list_len--;
        end
        res.count = list_len[COUNT_W-1:0];
        if (list_len > peak_len)
            peak_len = list_len;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic typed,
                                input list_result_t want);
        logic [IN_TDATA_W-1:0] word;
        list_result_t          predicted;
        int                    pause;
        word = '0;
        word[CMD_W-1:0] = cmd;
        word[CMD_W +: INDEX_W] = idx;
        word[CMD_W+INDEX_W +: VALUE_W] = val;
        pause = (source_gaps_on && $urandom_range(99) >= 60) ? gap_length() : 0;
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        apply_to_list(cmd, idx, val, predicted);
        pending_results.push_back(typed ? want : predicted);
        cmd_seen[cmd]++;
        status_seen[predicted.status]++;
        @(negedge aclk);
    endtask

    // sender goes quiet until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic add_row(input cmd_t cmd, input int idx, input logic [31:0] val,
                           input int reps, input int typed, input logic [31:0] wdata,
                           input status_t wstatus, input int wcount);
        plan_row_t row;
        row.cmd         = cmd;
        row.index       = idx[INDEX_W-1:0];
        row.value       = val;
        row.reps        = reps[7:0];
        row.typed       = (typed != 0);
        row.want.data   = wdata;
        row.want.status = wstatus;
        row.want.count  = wcount[COUNT_W-1:0];
        plan.push_back(row);
    endtask

    always @(posedge aclk) begin : result_check
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data   = m_tdata[DATA_W-1:0];
            got.status = m_tdata[DATA_W +: STATUS_W];
            got.count  = m_tdata[DATA_W+STATUS_W +: COUNT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", got.data, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data)
                    report_mismatch("data", got.data, want.data);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.count !== want.count)
                    report_mismatch("count", 32'(got.count), 32'(want.count));
                if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                    report_mismatch("fill bits", 32'(m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]),
                                    32'd0);
            end
        end
    end

    // result side: random stalls, plus the long hold-off on request
    initial begin : result_sink
        int stall_left;
        int seen_hold;
        stall_left = 0;
        seen_hold  = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != seen_hold) begin
                seen_hold  = hold_seq;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!sink_gaps_on || $urandom_range(99) < 65) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = gap_length() - 1;
                m_tready <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        plan_row_t          row;
        list_result_t       none;
        cmd_t               cmd;
        logic [INDEX_W-1:0] idx;
        logic [1:0]         mode;
        bit                 filling;
        int                 roll;
        int                 n;
        int                 r;

        none    = '0;
        filling = 1'b1;

        // empty-list errors, extremes, a fill to capacity and removals at both ends and in the middle
        add_row(CMD_READ,   0,   32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, 0);
        add_row(CMD_REMOVE, 0,   32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, 0);
        add_row(CMD_WRITE,  127, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_BAD_INDEX, 0);
        add_row(CMD_APPEND, 0,   32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK, 1);
        add_row(CMD_APPEND, 127, 32'h0000_0000, 1, 1, 32'h0, ST_OK, 2);
        add_row(CMD_READ,   0,   32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 2);
        add_row(CMD_READ,   1,   32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK, 2);
        add_row(CMD_READ,   2,   32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, 2);
        add_row(CMD_WRITE,  1,   32'hA5A5_5A5A, 1, 1, 32'h0, ST_OK, 2);
        add_row(CMD_READ,   1,   32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_REMOVE, 0,   32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_READ,   0,   32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_REMOVE, 0,   32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_APPEND, 0,   32'h1000_0000, LIST_DEPTH, 0, 32'h0, ST_OK, 0);
        add_row(CMD_APPEND, 0,   32'h5A5A_5A5A, 1, 1, 32'h0, ST_FULL, LIST_DEPTH);
        add_row(CMD_READ,   63,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_READ,   64,  32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, LIST_DEPTH);
        add_row(CMD_WRITE,  63,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_REMOVE, 0,   32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_REMOVE, 62,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(CMD_READ,   127, 32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, 62);
        add_row(CMD_APPEND, 5,   32'hC3C3_3C3C, 2, 0, 32'h0, ST_OK, 0);
        add_row(CMD_APPEND, 0,   32'h7777_8888, 1, 1, 32'h0, ST_FULL, LIST_DEPTH);
        add_row(CMD_REMOVE, 127, 32'h0000_0000, 1, 1, 32'h0, ST_BAD_INDEX, LIST_DEPTH);
        add_row(CMD_REMOVE, 31,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            for (r = 0; r < row.reps; r++)
                send_request(row.cmd, row.index, row.value ^ (r * 32'h9E37_79B9),
                             row.typed, row.typed ? row.want : none);
        end
        drain_results();

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 150 == 0) begin
                mode = 2'($urandom_range(3));
                source_gaps_on = mode[0];
                sink_gaps_on   = mode[1];
            end
            // long result-side hold-off while requests keep coming
            if (n == 400 || n == 1300) begin
                hold_seq++;
                source_gaps_on = 1'b0;
            end
            if (n == 800)
                drain_results();

            // swing occupancy between empty and full
            if (list_len == 0)
                filling = 1'b1;
            else if (list_len >= LIST_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if ($urandom_range(99) == 0)
                filling = !filling;

            roll = $urandom_range(99);
            if (roll < (filling ? 45 : 15))
                cmd = CMD_APPEND;
            else if (roll < (filling ? 65 : 40))
                cmd = CMD_READ;
            else if (roll < (filling ? 80 : 55))
                cmd = CMD_WRITE;
            else
                cmd = CMD_REMOVE;

            if (list_len == 0 || $urandom_range(99) < 10)
                idx = INDEX_W'($urandom_range(127));
            else
                idx = INDEX_W'($urandom_range(list_len - 1));

            send_request(cmd, idx, $urandom, 1'b0, none);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        foreach (pending_results[i])
            report_mismatch("result never arrived", 32'd0, pending_results[i].data);

        $display("summary: %0d requests: %0d append, %0d read, %0d write, %0d remove",
                 cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
                 cmd_seen[CMD_APPEND], cmd_seen[CMD_READ], cmd_seen[CMD_WRITE],
                 cmd_seen[CMD_REMOVE]);
        $display("summary: %0d bad index, %0d full list, peak occupancy %0d of %0d, %0d mismatches",
                 status_seen[ST_BAD_INDEX], status_seen[ST_FULL], peak_len, LIST_DEPTH,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cil_pkg.sv
hw/rtl/cil_ram.sv
hw/rtl/compacting_indexed_list.sv
bench/compacting_indexed_list_tb.sv
